[design/swarq_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding-window ARQ tracker package
// Shared widths, event codes and configuration register indexes.
// ----------------------------------------------------------------------------
package swarq_pkg;

    // Sequence number width (segment numbers on the link)
    localparam int SEQ_BITS = 16;

    // Default number of bitmap bits on each side
    localparam int MAX_WINDOW_DEF = 32;

    // Configuration register widths and reset values
    localparam int WINDOW_SIZE_W = 6;
    localparam int TOTAL_SEG_W   = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST = 6'd8;
    localparam logic [TOTAL_SEG_W-1:0]   TOTAL_SEG_RST   = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_SEGMENTS = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_FIELD_W = 1 + SEQ_BITS + 1 + SEQ_BITS + SEQ_BITS + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Link events
    typedef enum logic [S_TUSER_W-1:0] {
        CMD_TX_DONE = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_ACK     = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_t;

endpackage

[design/sliding_window_arq_tracker.sv]
// ----------------------------------------------------------------------------
// Sliding-window ARQ tracker
// Selective-repeat sender and receiver window bookkeeping, one link event
// per item, one result item per event.
// ----------------------------------------------------------------------------
// Each input item is one link event (tuser) with a segment number (tdata).
// The block is ready only when idle; an item then runs through a small
// sequencer that drives one shared add/subtract unit and walks the window
// bitmaps one bit per cycle. An item passes through ST_OFFSET, then for
// some events a receiver slide (ST_RSHIFT), a sender shift (ST_SSHIFT)
// and/or a search for the first unsent segment (ST_SCAN, ST_CHECK), and
// then ST_FIN; a stale timeout goes from ST_OFFSET straight to ST_FIN. The
// longest case is an ACK that slides the sender window and then searches
// it. The result item then waits in the output register until taken; the
// next item is accepted in the cycle after that, so a new item is never
// taken while the last one is still in progress. After reset segment 0
// counts as in flight and the sender is busy. Configuration writes take
// effect at once and are meant to be issued only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_arq_tracker #(
    parameter int MAX_WINDOW = swarq_pkg::MAX_WINDOW_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swarq_pkg::S_TDATA_W-1:0]    s_tdata,    // [15:0] seq
    input  logic [swarq_pkg::S_TUSER_W-1:0]    s_tuser,    // [1:0] cmd
    // Result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] tx_start, [16:1] tx_seq, [17] ack_valid, [33:18] ack_seq,
    // [49:34] sender_base_out, [50] finished, [55:51] zero
    output logic [swarq_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration writes
    input  logic                               cfg_we,
    input  logic [swarq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [swarq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import swarq_pkg::*;

    localparam int MAP_W = MAX_WINDOW;
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (WIN_W > WINDOW_SIZE_W) ? WIN_W : WINDOW_SIZE_W;
    localparam int PAD_W = M_TDATA_W - M_FIELD_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_OFFSET = 8'b0000_0010,
        ST_RSHIFT = 8'b0000_0100,
        ST_SSHIFT = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_CHECK  = 8'b0010_0000,
        ST_FIN    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    // Control and window state
    state_t                     state_reg, state_next;
    logic [WINDOW_SIZE_W-1:0]   window_size_reg, window_size_next;
    logic [TOTAL_SEG_W-1:0]     total_reg, total_next;
    logic [SEQ_BITS-1:0]        sender_base_reg, sender_base_next;
    logic [MAP_W-1:0]           sent_map_reg, sent_map_next;
    logic [SEQ_BITS-1:0]        receiver_base_reg, receiver_base_next;
    logic [MAP_W-1:0]           received_map_reg, received_map_next;
    logic                       busy_reg, busy_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    // Per-item working registers
    cmd_t                       cmd_reg, cmd_next;
    logic [SEQ_BITS-1:0]        seq_reg, seq_next;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic [WIN_W-1:0]           pos_reg, pos_next;
    logic                       tx_start_reg, tx_start_next;
    logic [SEQ_BITS-1:0]        tx_seq_reg, tx_seq_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    // Shared add/subtract unit
    logic [SEQ_BITS-1:0]        alu_a, alu_b;
    logic                       alu_sub;
    logic [SEQ_BITS:0]          alu_sum;
    logic                       alu_carry;
    logic [SEQ_BITS-1:0]        alu_diff;

    // Derived values
    logic [CMP_W-1:0]           ws_wide;
    logic [WIN_W-1:0]           eff_win;
    logic                       off_small;
    logic                       in_rwin;
    logic [MAP_W-1:0]           bit_mask;
    logic                       ack_flag;
    logic [SEQ_BITS-1:0]        ack_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Clamp the window to the bitmap size
    assign ws_wide = CMP_W'(window_size_reg);
    assign eff_win = (ws_wide > CMP_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : WIN_W'(ws_wide);

    // Operand selection for the shared unit
    always_comb begin
        alu_a   = seq_reg;
        alu_b   = sender_base_reg;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_OFFSET: begin
                // offset of the event's segment from the matching base
                alu_a   = seq_reg;
                alu_b   = (cmd_reg == CMD_DATA) ? receiver_base_reg : sender_base_reg;
                alu_sub = 1'b1;
            end
            ST_RSHIFT: begin
                // slide the receiver base by one
                alu_a   = receiver_base_reg;
                alu_b   = SEQ_BITS'(1);
                alu_sub = 1'b0;
            end
            ST_CHECK: begin
                // candidate segment number
                alu_a   = sender_base_reg;
                alu_b   = SEQ_BITS'(pos_reg);
                alu_sub = 1'b0;
            end
            ST_FIN: begin
                // finished flag: sender base against total
                alu_a   = sender_base_reg;
                alu_b   = total_reg;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = seq_reg;
                alu_b   = sender_base_reg;
                alu_sub = 1'b1;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {SEQ_BITS{alu_sub}}}
                     + (SEQ_BITS + 1)'(alu_sub);
    assign alu_carry = alu_sum[SEQ_BITS];
    assign alu_diff  = alu_sum[SEQ_BITS-1:0];

    assign off_small = alu_diff < SEQ_BITS'(MAX_WINDOW);
    assign in_rwin   = alu_carry && (alu_diff < SEQ_BITS'(eff_win));
    assign bit_mask  = MAP_W'(1) << alu_diff[IDX_W-1:0];

    assign ack_flag  = (cmd_reg == CMD_DATA);
    assign ack_val   = ack_flag ? receiver_base_reg : '0;

    // Sequencer
    always_comb begin
        state_next         = state_reg;
        window_size_next   = window_size_reg;
        total_next         = total_reg;
        sender_base_next   = sender_base_reg;
        sent_map_next      = sent_map_reg;
        receiver_base_next = receiver_base_reg;
        received_map_next  = received_map_reg;
        busy_next          = busy_reg;
        m_tvalid_next      = m_tvalid_reg;
        cmd_next           = cmd_reg;
        seq_next           = seq_reg;
        cnt_next           = cnt_reg;
        pos_next           = pos_reg;
        tx_start_next      = tx_start_reg;
        tx_seq_next        = tx_seq_reg;
        m_tdata_next       = m_tdata_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE:    window_size_next = cfg_wdata[WINDOW_SIZE_W-1:0];
                CFG_TOTAL_SEGMENTS: total_next       = cfg_wdata[TOTAL_SEG_W-1:0];
                default:            ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                // Take the event and clear the per-item result
                if (s_tvalid) begin
                    cmd_next      = cmd_t'(s_tuser);
                    seq_next      = s_tdata[SEQ_BITS-1:0];
                    tx_start_next = 1'b0;
                    tx_seq_next   = '0;
                    state_next    = ST_OFFSET;
                end
            end

            ST_OFFSET: begin
                pos_next = '0;
                unique case (cmd_reg)
                    CMD_TX_DONE: begin
                        // Mark the segment done and free the transmitter
                        busy_next = 1'b0;
                        if (alu_carry && off_small) begin
                            sent_map_next = sent_map_reg | bit_mask;
                        end
                        state_next = ST_SCAN;
                    end
                    CMD_DATA: begin
                        if (in_rwin) begin
                            received_map_next = received_map_reg | bit_mask;
                        end
                        state_next = ST_RSHIFT;
                    end
                    CMD_ACK: begin
                        state_next = busy_reg ? ST_FIN : ST_SCAN;
                        if (alu_carry) begin
                            sender_base_next = seq_reg;
                            if (!off_small) begin
                                sent_map_next = '0;
                            end else if (alu_diff != '0) begin
                                cnt_next   = alu_diff[IDX_W-1:0];
                                state_next = ST_SSHIFT;
                            end
                        end
                    end
                    CMD_TIMEOUT: begin
                        // Stale timeouts are dropped entirely
                        state_next = ST_FIN;
                        if (alu_carry) begin
                            if (off_small) begin
                                sent_map_next = sent_map_reg & ~bit_mask;
                            end
                            if (!busy_reg) begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    default: state_next = ST_FIN;
                endcase
            end

            ST_RSHIFT: begin
                // Slide past contiguous received segments
                if (received_map_reg[0]) begin
                    received_map_next  = received_map_reg >> 1;
                    receiver_base_next = alu_diff;
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_SSHIFT: begin
                // Drop acknowledged bits one per cycle
                sent_map_next = sent_map_reg >> 1;
                cnt_next      = cnt_reg - IDX_W'(1);
                if (cnt_reg == IDX_W'(1)) begin
                    state_next = busy_reg ? ST_FIN : ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Find the lowest unsent bit inside the window
                if (pos_reg == eff_win) begin
                    state_next = ST_FIN;
                end else if (!sent_map_reg[pos_reg[IDX_W-1:0]]) begin
                    state_next = ST_CHECK;
                end else begin
                    pos_next = pos_reg + WIN_W'(1);
                end
            end

            ST_CHECK: begin
                // Start only below the total segment count
                if (alu_sum < {1'b0, total_reg}) begin
                    tx_start_next = 1'b1;
                    tx_seq_next   = alu_diff;
                    busy_next     = 1'b1;
                end
                state_next = ST_FIN;
            end

            ST_FIN: begin
                // Assemble the result item
                m_tdata_next = {PAD_W'(0), alu_carry, sender_base_reg, ack_val,
                                ack_flag, tx_seq_reg, tx_start_reg};
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT;
            end

            ST_OUT: begin
                // Hold the result until taken
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            window_size_reg   <= WINDOW_SIZE_RST;
            total_reg         <= TOTAL_SEG_RST;
            sender_base_reg   <= '0;
            sent_map_reg      <= MAP_W'(1);
            receiver_base_reg <= '0;
            received_map_reg  <= '0;
            busy_reg          <= 1'b1;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            window_size_reg   <= window_size_next;
            total_reg         <= total_next;
            sender_base_reg   <= sender_base_next;
            sent_map_reg      <= sent_map_next;
            receiver_base_reg <= receiver_base_next;
            received_map_reg  <= received_map_next;
            busy_reg          <= busy_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        seq_reg      <= seq_next;
        cnt_reg      <= cnt_next;
        pos_reg      <= pos_next;
        tx_start_reg <= tx_start_next;
        tx_seq_reg   <= tx_seq_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule
